// ===== rtl/ucd_pkg.sv =====
package ucd_pkg;

    localparam int END_W = 10;
    localparam int CNT_W = 10;

    localparam logic MODE_EDGE   = 1'b0;
    localparam logic MODE_FINISH = 1'b1;

    // One queued item, already classified by the front end.
    typedef struct packed {
        logic             mode;
        logic             bad_end;
        logic [END_W-1:0] end_a;
        logic [END_W-1:0] end_b;
    } ucd_item_t;

endpackage

// ===== rtl/ucd_ram.sv =====
module ucd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== rtl/ucd_front.sv =====
module ucd_front
    import ucd_pkg::*;
#(
    parameter int MAX_NODES = 1024
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic             in_mode,
    input  logic [END_W-1:0] in_end_a,
    input  logic [END_W-1:0] in_end_b,
    output logic             item_valid,
    input  logic             item_ready,
    output ucd_item_t        item
);

    localparam int QDEPTH = 2;

    ucd_item_t  q_reg [QDEPTH];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    ucd_item_t  new_item;
    logic       push, pop;

    always_comb begin
        new_item.mode    = in_mode;
        new_item.end_a   = in_end_a;
        new_item.end_b   = in_end_b;
        // Endpoints the node store cannot hold make the edge a dropped one.
        new_item.bad_end = (32'(in_end_a) >= 32'(MAX_NODES)) ||
                           (32'(in_end_b) >= 32'(MAX_NODES));
    end

    assign in_ready   = (count_reg != 2'(QDEPTH));
    assign item_valid = (count_reg != 2'd0);
    assign item       = q_reg[rd_ptr_reg];
    assign push       = in_valid && in_ready;
    assign pop        = item_valid && item_ready;

    always_comb begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
        if (push) begin
            q_reg[wr_ptr_reg] <= new_item;
        end
    end

endmodule

// ===== rtl/ucd_engine.sv =====
module ucd_engine
    import ucd_pkg::*;
#(
    parameter int MAX_NODES = 1024,
    parameter int MAX_EDGES = 4096
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic [CNT_W-1:0] node_count,
    input  logic             item_valid,
    output logic             item_ready,
    input  ucd_item_t        item,
    output logic             res_valid,
    input  logic             res_ready,
    output logic             res_cycle,
    output logic             res_dropped,
    output logic             clearing
);

    localparam int SLOTS = 2 * MAX_EDGES;
    localparam int NW    = $clog2(MAX_NODES);
    localparam int SAW   = $clog2(SLOTS);
    localparam int SW    = SAW + 1;
    localparam int DW    = NW + 1;
    localparam int FW    = 2 * NW + 1 + SW;
    localparam logic [SW-1:0] NIL = SW'(SLOTS);

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_E1, S_E2, S_SCAN, S_SCANW, S_START,
        S_STEP, S_STEPW, S_STEPS, S_PUSHW, S_POPW, S_DONE
    } state_t;

    state_t         state_reg;
    logic [NW-1:0]  clr_reg;
    logic [SW-1:0]  used_reg;
    logic           ovf_reg;
    logic [NW-1:0]  a_reg, b_reg;
    logic [DW-1:0]  i_reg;
    logic [NW-1:0]  last_reg;
    logic           cyc_reg;
    logic [DW-1:0]  depth_reg;
    logic [NW-1:0]  node_reg, parent_reg, t_reg;
    logic           hasp_reg;
    logic [SW-1:0]  cursor_reg;
    logic           res_valid_reg, res_cycle_reg, res_dropped_reg;

    logic           head_we, seen_we, seen_wd, slot_we, stk_we;
    logic [NW-1:0]  head_wa, head_ra, seen_wa, seen_ra, stk_wa, stk_ra;
    logic [SW-1:0]  head_wd, head_rd, slot_nwd, slot_nrd, b_next;
    logic [SAW-1:0] slot_wa;
    logic [NW-1:0]  slot_twd, slot_trd;
    logic           seen_rd;
    logic [FW-1:0]  stk_wd, stk_rd;
    logic           no_room;
    logic [NW-1:0]  last_next;

    assign item_ready  = (state_reg == S_IDLE);
    assign clearing    = (state_reg == S_CLEAR);
    assign res_valid   = res_valid_reg;
    assign res_cycle   = res_cycle_reg;
    assign res_dropped = res_dropped_reg;

    assign no_room   = ({1'b0, used_reg} + (SW + 1)'(2)) > (SW + 1)'(SLOTS);
    assign last_next = (32'(node_count) > 32'(MAX_NODES - 1)) ? NW'(MAX_NODES - 1)
                                                                : NW'(node_count);
    // A self-loop reads its own head while it is being written; take the new slot.
    assign b_next    = (a_reg == b_reg) ? used_reg : head_rd;

    always_comb begin
        head_we  = 1'b0;
        head_wa  = a_reg;
        head_wd  = used_reg;
        head_ra  = i_reg[NW-1:0];
        seen_we  = 1'b0;
        seen_wa  = i_reg[NW-1:0];
        seen_wd  = 1'b1;
        seen_ra  = i_reg[NW-1:0];
        slot_we  = 1'b0;
        slot_wa  = used_reg[SAW-1:0];
        slot_twd = b_reg;
        slot_nwd = head_rd;
        stk_we   = 1'b0;
        stk_wa   = NW'(depth_reg - DW'(1));
        stk_ra   = NW'(depth_reg - DW'(2));
        stk_wd   = {node_reg, parent_reg, hasp_reg, cursor_reg};
        case (state_reg)
            S_CLEAR: begin
                head_we = 1'b1;
                head_wa = clr_reg;
                head_wd = NIL;
                seen_we = 1'b1;
                seen_wa = clr_reg;
                seen_wd = 1'b0;
            end
            S_IDLE: begin
                head_ra = NW'(item.end_a);
            end
            S_E1: begin
                head_we = 1'b1;
                slot_we = 1'b1;
                head_ra = b_reg;
            end
            S_E2: begin
                head_we  = 1'b1;
                head_wa  = b_reg;
                head_wd  = used_reg + SW'(1);
                slot_we  = 1'b1;
                slot_wa  = SAW'(used_reg + SW'(1));
                slot_twd = a_reg;
                slot_nwd = b_next;
            end
            S_SCANW: begin
                seen_we = !seen_rd;
            end
            S_STEPW: begin
                seen_ra = slot_trd;
            end
            S_STEPS: begin
                head_ra = t_reg;
                if (!seen_rd && (32'(depth_reg) < 32'(MAX_NODES))) begin
                    seen_we = 1'b1;
                    seen_wa = t_reg;
                    stk_we  = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    ucd_ram #(.WIDTH(SW), .DEPTH(MAX_NODES)) u_head (
        .aclk(aclk), .we(head_we), .waddr(head_wa), .wdata(head_wd),
        .raddr(head_ra), .rdata(head_rd)
    );

    ucd_ram #(.WIDTH(1), .DEPTH(MAX_NODES)) u_seen (
        .aclk(aclk), .we(seen_we), .waddr(seen_wa), .wdata(seen_wd),
        .raddr(seen_ra), .rdata(seen_rd)
    );

    ucd_ram #(.WIDTH(NW), .DEPTH(SLOTS)) u_slot_target (
        .aclk(aclk), .we(slot_we), .waddr(slot_wa), .wdata(slot_twd),
        .raddr(cursor_reg[SAW-1:0]), .rdata(slot_trd)
    );

    ucd_ram #(.WIDTH(SW), .DEPTH(SLOTS)) u_slot_next (
        .aclk(aclk), .we(slot_we), .waddr(slot_wa), .wdata(slot_nwd),
        .raddr(cursor_reg[SAW-1:0]), .rdata(slot_nrd)
    );

    ucd_ram #(.WIDTH(FW), .DEPTH(MAX_NODES)) u_stack (
        .aclk(aclk), .we(stk_we), .waddr(stk_wa), .wdata(stk_wd),
        .raddr(stk_ra), .rdata(stk_rd)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_CLEAR;
            clr_reg       <= '0;
            used_reg      <= '0;
            ovf_reg       <= 1'b0;
            res_valid_reg <= 1'b0;
        end else begin
            if (res_valid_reg && res_ready) begin
                res_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_CLEAR: begin
                    used_reg <= '0;
                    ovf_reg  <= 1'b0;
                    if (32'(clr_reg) == 32'(MAX_NODES - 1)) begin
                        state_reg <= S_IDLE;
                    end else begin
                        clr_reg <= clr_reg + NW'(1);
                    end
                end
                S_IDLE: begin
                    if (item_valid) begin
                        a_reg <= NW'(item.end_a);
                        b_reg <= NW'(item.end_b);
                        if (item.mode == MODE_FINISH) begin
                            i_reg     <= DW'(1);
                            last_reg  <= last_next;
                            cyc_reg   <= 1'b0;
                            state_reg <= (node_count == '0) ? S_DONE : S_SCAN;
                        end else if (item.bad_end || no_room) begin
                            ovf_reg <= 1'b1;
                        end else begin
                            state_reg <= S_E1;
                        end
                    end
                end
                S_E1: begin
                    state_reg <= S_E2;
                end
                S_E2: begin
                    used_reg  <= used_reg + SW'(2);
                    state_reg <= S_IDLE;
                end
                S_SCAN: begin
                    state_reg <= (i_reg > {1'b0, last_reg}) ? S_DONE : S_SCANW;
                end
                S_SCANW: begin
                    if (seen_rd) begin
                        i_reg     <= i_reg + DW'(1);
                        state_reg <= S_SCAN;
                    end else begin
                        state_reg <= S_START;
                    end
                end
                S_START: begin
                    node_reg   <= i_reg[NW-1:0];
                    parent_reg <= '0;
                    hasp_reg   <= 1'b0;
                    cursor_reg <= head_rd;
                    depth_reg  <= DW'(1);
                    state_reg  <= S_STEP;
                end
                S_STEP: begin
                    if (cursor_reg >= NIL) begin
                        if (depth_reg == DW'(1)) begin
                            i_reg     <= i_reg + DW'(1);
                            state_reg <= S_SCAN;
                        end else begin
                            depth_reg <= depth_reg - DW'(1);
                            state_reg <= S_POPW;
                        end
                    end else begin
                        state_reg <= S_STEPW;
                    end
                end
                S_POPW: begin
                    {node_reg, parent_reg, hasp_reg, cursor_reg} <= stk_rd;
                    state_reg <= S_STEP;
                end
                S_STEPW: begin
                    t_reg      <= slot_trd;
                    cursor_reg <= slot_nrd;
                    state_reg  <= S_STEPS;
                end
                S_STEPS: begin
                    if (!seen_rd) begin
                        // A full stack skips the neighbor and keeps scanning.
                        state_reg <= (32'(depth_reg) < 32'(MAX_NODES)) ? S_PUSHW : S_STEP;
                    end else if (!hasp_reg || (t_reg != parent_reg)) begin
                        cyc_reg   <= 1'b1;
                        state_reg <= S_DONE;
                    end else begin
                        state_reg <= S_STEP;
                    end
                end
                S_PUSHW: begin
                    parent_reg <= node_reg;
                    node_reg   <= t_reg;
                    hasp_reg   <= 1'b1;
                    cursor_reg <= head_rd;
                    depth_reg  <= depth_reg + DW'(1);
                    state_reg  <= S_STEP;
                end
                S_DONE: begin
                    if (!res_valid_reg) begin
                        res_valid_reg   <= 1'b1;
                        res_cycle_reg   <= cyc_reg;
                        res_dropped_reg <= ovf_reg;
                        clr_reg         <= '0;
                        state_reg       <= S_CLEAR;
                    end
                end
                default: begin
                    state_reg <= S_CLEAR;
                end
            endcase
        end
    end

endmodule

// ===== rtl/undirected_cycle_detect_unit.sv =====
// Undirected cycle detector.
// Input stream: each beat is one item. s_tuser is the mode: 0 stores the edge
// end_a--end_b (s_tdata), 1 closes the graph and runs the check. Edges with an
// endpoint of MAX_NODES or more, or beyond MAX_EDGES, are dropped and flagged.
// Output stream: one beat per finish item carrying cycle_found and
// edges_dropped. No beat is produced for an edge item.
// Configuration: cfg_data sets node_count; walks start at nodes 1..node_count (at most MAX_NODES-1).
// Back end: an edge is handled as a head read, then one slot write per
// direction. A finish tests each starting node, starts a walk from each one
// not yet visited, reads adjacency entries, enters and leaves nodes, and posts
// the result; every step waits on a registered memory read. After each
// result, and after reset, a clearing pass over all MAX_NODES entries empties
// the list heads and visited marks; s_tready is low while it runs.
// A two-entry queue decouples the input from the back end, and the result sits
// in an output register, so a stalled receiver only holds the back end once the
// next result is ready.
module undirected_cycle_detect_unit
    import ucd_pkg::*;
#(
    parameter int MAX_NODES = 1024,
    parameter int MAX_EDGES = 4096
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [CNT_W-1:0] cfg_data,   // node_count
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [23:0]      s_tdata,    // end_a [9:0], end_b [19:10], zeros above
    input  logic             s_tuser,    // mode
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [7:0]       m_tdata     // cycle_found [0], edges_dropped [1], zeros above
);

    logic [CNT_W-1:0] node_count_reg;
    logic             front_ready, item_valid, item_ready, eng_clearing;
    logic             res_cycle, res_dropped;
    ucd_item_t        item;

    assign cfg_ready = 1'b1;
    assign s_tready  = front_ready && !eng_clearing;
    assign m_tdata   = {6'd0, res_dropped, res_cycle};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            node_count_reg <= CNT_W'(1);
        end else if (cfg_valid) begin
            node_count_reg <= cfg_data;
        end
    end

    ucd_front #(.MAX_NODES(MAX_NODES)) u_front (
        .aclk(aclk), .aresetn(aresetn),
        .in_valid(s_tvalid && !eng_clearing), .in_ready(front_ready),
        .in_mode(s_tuser), .in_end_a(s_tdata[9:0]), .in_end_b(s_tdata[19:10]),
        .item_valid(item_valid), .item_ready(item_ready), .item(item)
    );

    ucd_engine #(.MAX_NODES(MAX_NODES), .MAX_EDGES(MAX_EDGES)) u_engine (
        .aclk(aclk), .aresetn(aresetn), .node_count(node_count_reg),
        .item_valid(item_valid), .item_ready(item_ready), .item(item),
        .res_valid(m_tvalid), .res_ready(m_tready),
        .res_cycle(res_cycle), .res_dropped(res_dropped),
        .clearing(eng_clearing)
    );

    // A new result is always followed by the clearing pass.
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> eng_clearing)
        else $error("result without clearing pass");

    // No item enters while the node store is being cleared.
    assert property (@(posedge aclk) disable iff (!aresetn)
        eng_clearing |-> !s_tready)
        else $error("input accepted during clearing pass");

    // The back end takes no item from the queue during the clearing pass.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (item_ready && item_valid) |-> !eng_clearing)
        else $error("item popped during clearing pass");

endmodule

// ===== test/undirected_cycle_detect_unit_test.sv =====
module undirected_cycle_detect_unit_test;
    import ucd_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NODES = 1024;
    localparam int SLOTS = 2 * 4096;
    localparam int NIL = SLOTS;
    localparam int LIMIT = 6000000;

    typedef struct packed {
        logic             mode;
        logic [END_W-1:0] end_a;
        logic [END_W-1:0] end_b;
    } beat_t;

    typedef struct packed {
        logic cycle_found;
        logic edges_dropped;
    } verdict_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [CNT_W-1:0] cfg_data = '0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [23:0] s_tdata = '0;
    logic s_tuser = 1'b0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [7:0] m_tdata;

    undirected_cycle_detect_unit u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Graph shadow used by the predictor.
    int unsigned graph_nodes = 1;
    int unsigned head_of[NODES];
    int unsigned slot_dest[SLOTS];
    int unsigned slot_link[SLOTS];
    bit          visited[NODES];
    int unsigned fill = 0;
    bit          dropped = 1'b0;
    int unsigned st_node[NODES];
    int unsigned st_par[NODES];
    bit          st_haspar[NODES];
    int unsigned st_cur[NODES];

    beat_t    pending_beats[$];
    verdict_t expected_verdicts[$];
    int       errors = 0;
    int       mismatches = 0;
    bit       calm = 1'b0;
    bit       hold_send = 1'b0;
    int       cycles = 0;

    task automatic clear_shadow();
        for (int i = 0; i < NODES; i++) begin
            head_of[i] = NIL;
            visited[i] = 1'b0;
        end
        fill = 0;
        dropped = 1'b0;
    endtask

    function automatic bit search_from(int unsigned start);
        int unsigned depth;
        int unsigned s;
        int unsigned t;
        depth = 1;
        visited[start] = 1'b1;
        st_node[0] = start;
        st_haspar[0] = 1'b0;
        st_par[0] = 0;
        st_cur[0] = head_of[start];
        while (depth > 0) begin
            s = st_cur[depth-1];
            if (s >= SLOTS) begin
                depth--;
                continue;
            end
            t = slot_dest[s];
            st_cur[depth-1] = slot_link[s];
            if (!visited[t]) begin
                if (depth >= NODES) continue;
                visited[t] = 1'b1;
                st_node[depth] = t;
                st_par[depth] = st_node[depth-1];
                st_haspar[depth] = 1'b1;
                st_cur[depth] = head_of[t];
                depth++;
            end else if (!st_haspar[depth-1] || t != st_par[depth-1]) begin
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    task automatic predict_beat(beat_t b);
        verdict_t v;
        int unsigned last;
        if (b.mode == MODE_EDGE) begin
            if (fill + 2 > SLOTS) begin
                dropped = 1'b1;
            end else begin
                slot_dest[fill] = b.end_b;
                slot_link[fill] = head_of[b.end_a];
                head_of[b.end_a] = fill;
                fill++;
                slot_dest[fill] = b.end_a;
                slot_link[fill] = head_of[b.end_b];
                head_of[b.end_b] = fill;
                fill++;
            end
        end else begin
            v.cycle_found = 1'b0;
            last = (graph_nodes > NODES - 1) ? NODES - 1 : graph_nodes;
            for (int unsigned i = 1; i <= last && !v.cycle_found; i++)
                if (!visited[i]) v.cycle_found = search_from(i);
            v.edges_dropped = dropped;
            expected_verdicts = {expected_verdicts, v};
            clear_shadow();
        end
    endtask

    function automatic bit idle_now();
        return !calm && ($urandom_range(99) < 36);
    endfunction

    // Driver: holds a beat until it is taken, then loads the next one.
    always @(posedge aclk) begin
        cycles++;
        if (cycles > LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
        if (aresetn) begin
            if (s_tvalid && s_tready) predict_beat({s_tuser, s_tdata[9:0], s_tdata[19:10]});
            if (!(s_tvalid && !s_tready)) begin
                if (pending_beats.size() > 0 && !hold_send && !idle_now()) begin
                    beat_t nb;
                    nb = pending_beats.pop_front();
                    s_tvalid <= 1'b1;
                    s_tuser <= nb.mode;
                    s_tdata <= {4'b0, nb.end_b, nb.end_a};
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Monitor.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                if (expected_verdicts.size() == 0) begin
                    errors++;
                    if (mismatches++ < 10) $display("unexpected result beat %h", m_tdata);
                end else begin
                    verdict_t e;
                    e = expected_verdicts.pop_front();
                    if (m_tdata[0] !== e.cycle_found || m_tdata[1] !== e.edges_dropped ||
                        m_tdata[7:2] !== 6'b0) begin
                        errors++;
                        if (mismatches++ < 10)
                            $display("result mismatch: expected cycle=%0b dropped=%0b, got %h",
                                     e.cycle_found, e.edges_dropped, m_tdata);
                    end
                end
            end
            m_tready <= !idle_now();
        end
    end

    task automatic write_nodes(int unsigned n);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_data <= n[CNT_W-1:0];
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        graph_nodes = n;
    endtask

    task automatic queue_beat(bit m, int unsigned a, int unsigned b);
        beat_t x;
        x.mode = m;
        x.end_a = a[END_W-1:0];
        x.end_b = b[END_W-1:0];
        pending_beats = {pending_beats, x};
    endtask

    task automatic drain();
        while (pending_beats.size() > 0 || s_tvalid || expected_verdicts.size() > 0)
            @(posedge aclk);
        repeat (NODES + 50) @(posedge aclk);
    endtask

    // One random graph: mostly small node sets, edges within range.
    task automatic queue_graph(int unsigned span, int unsigned edges);
        for (int unsigned k = 0; k < edges; k++) begin
            if ($urandom_range(19) == 0)
                queue_beat(MODE_EDGE, $urandom_range(1023), $urandom_range(1023));
            else
                queue_beat(MODE_EDGE, $urandom_range(span), $urandom_range(span));
        end
        queue_beat(MODE_FINISH, $urandom, $urandom);
    endtask

    initial begin
        int unsigned span;
        clear_shadow();
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        write_nodes(5);
        // Directed: tree, self-loop, repeated edge, node zero, extremes.
        queue_beat(MODE_EDGE, 1, 2);
        queue_beat(MODE_EDGE, 2, 3);
        queue_beat(MODE_FINISH, 0, 0);
        queue_beat(MODE_EDGE, 4, 4);
        queue_beat(MODE_FINISH, 1023, 1023);
        queue_beat(MODE_EDGE, 1, 2);
        queue_beat(MODE_EDGE, 2, 1);
        queue_beat(MODE_FINISH, 0, 0);
        queue_beat(MODE_EDGE, 0, 1);
        queue_beat(MODE_EDGE, 0, 2);
        queue_beat(MODE_EDGE, 1, 2);
        queue_beat(MODE_FINISH, 0, 0);
        queue_beat(MODE_EDGE, 1023, 1);
        queue_beat(MODE_EDGE, 1023, 512);
        queue_beat(MODE_EDGE, 512, 1);
        queue_beat(MODE_FINISH, 0, 0);
        drain();
        write_nodes(0);
        queue_beat(MODE_EDGE, 1, 1);
        queue_beat(MODE_FINISH, 0, 0);
        drain();
        write_nodes(1023);
        queue_beat(MODE_EDGE, 1022, 1023);
        queue_beat(MODE_EDGE, 1023, 1022);
        queue_beat(MODE_FINISH, 0, 0);
        queue_beat(MODE_FINISH, 0, 0);
        drain();
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: write_nodes(16);
                1: write_nodes($urandom_range(2, 64));
                2: write_nodes(1023);
                default: write_nodes(8);
            endcase
            calm = (phase == 1);
            for (int g = 0; g < 55; g++) begin
                span = (graph_nodes > 40) ? $urandom_range(4, 40) : graph_nodes + 1;
                queue_graph(span, $urandom_range(0, 12));
                if (g == 20) begin
                    hold_send = 1'b1;
                    while (s_tvalid || expected_verdicts.size() > 0 ||
                           pending_beats.size() == 0) @(posedge aclk);
                    hold_send = 1'b0;
                end
            end
            drain();
        end
        calm = 1'b0;
        if (errors == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/ucd_pkg.sv
rtl/ucd_ram.sv
rtl/ucd_front.sv
rtl/ucd_engine.sv
rtl/undirected_cycle_detect_unit.sv
test/undirected_cycle_detect_unit_test.sv
